// ===== design/assert_macros.svh =====
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dtcs_pkg.sv =====
package dtcs_pkg;

  typedef enum logic [1:0] {
    MODE_SAMPLE    = 2'd0,
    MODE_CAL_START = 2'd1,
    MODE_CAL_STOP  = 2'd2,
    MODE_RECOMPUTE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_LEFT_DZ   = 2'd0,
    REG_RIGHT_DZ  = 2'd1,
    REG_LEFT_OFF  = 2'd2,
    REG_RIGHT_OFF = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/dtcs_divider.sv =====
module dtcs_divider #(
  parameter int DW = 20,
  parameter int VW = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output dtcs_pkg::div_stat_t stat
);
  import dtcs_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [VW:0]   rem_sh;
  logic          fits;
  logic [VW:0]   rem_sub;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, q_r[DW-1]};
  assign fits    = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      q_r    <= '0;
      rem_r  <= '0;
      div_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
        cnt_r  <= CW'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[DW-2:0], fits};
        rem_r <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== design/dual_trigger_calibrate_scale.sv =====
// channel  direction  tdata (low bit up)                              tuser
// in_      slave      left_sample, right_sample                       mode
// out_     master     left_raw, right_raw, left_scaled, right_scaled  is_calibrating, ack
// cfg_     write      register index on cfg_addr, value on cfg_wdata
//
// a sample tick goes from accept through S_MUL_L, S_MUL_R and S_SAT_R to S_DONE;
// while calibrating it, and a calibration start, go straight to S_DONE
// recompute and calibration stop run the shared restoring divider once per
// channel, left then right, each in its S_DIV and S_WAIT state, then go to S_DONE
// the two channels share one multiplier and one divider, so items go one at a time
// reset is synchronous on rst_n, no clearing pass; a result waits in the output
// register while out_tready is low and the next request may already be taken
`include "assert_macros.svh"

module dual_trigger_calibrate_scale #(
  parameter int SAMPLE_BITS   = 12,
  parameter int FRACTION_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // mode
  input  dtcs_pkg::mode_t                       in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // left_raw, right_raw, left_scaled, right_scaled
  output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,
  // is_calibrating, ack
  output logic [1:0]                            out_tuser,
  input  logic                                  cfg_wen,
  input  dtcs_pkg::cfg_reg_t                    cfg_addr,
  input  logic [SAMPLE_BITS-1:0]                cfg_wdata
);
  import dtcs_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int FB    = FRACTION_BITS;
  localparam int OUT_W = ((4*SB+7)/8)*8;
  localparam int QW    = SB + FB;
  localparam int PW    = 2*SB + FB;
  localparam logic [SB-1:0] FULL      = {SB{1'b1}};
  localparam logic [QW-1:0] DIVIDEND  = {FULL, {FB{1'b0}}};
  localparam logic [QW-1:0] UNITY     = QW'(1) << FB;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_L, S_MUL_R, S_SAT_R, S_DIV_L, S_WAIT_L, S_DIV_R, S_WAIT_R, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [SB-1:0] ldz_r, rdz_r;
  logic          loff_r, roff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldz_r  <= '0;
      rdz_r  <= '0;
      loff_r <= 1'b0;
      roff_r <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_LEFT_DZ:   ldz_r  <= cfg_wdata;
        REG_RIGHT_DZ:  rdz_r  <= cfg_wdata;
        REG_LEFT_OFF:  loff_r <= cfg_wdata[0];
        REG_RIGHT_OFF: roff_r <= cfg_wdata[0];
      endcase
    end
  end

  // calibration state
  logic          cal_r;
  logic [SB-1:0] llow_r, lhigh_r, rlow_r, rhigh_r;
  logic [SB:0]   lthr_r, rthr_r;
  logic [QW-1:0] lscale_r, rscale_r;

  // per-item work registers
  logic [SB-1:0] ls_r, rs_r, lsc_r, rsc_r;
  logic          ack_r;
  logic [PW-1:0] prod_r;

  // output register
  logic          out_valid_r;
  logic [SB-1:0] out_ls_r, out_rs_r, out_lsc_r, out_rsc_r;
  logic          out_cal_r, out_ack_r;

  logic [SB-1:0] ls_nxt, rs_nxt;
  logic [SB:0]   lthr_nxt, rthr_nxt;
  logic          accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign ls_nxt    = loff_r ? '0 : in_tdata[SB-1:0];
  assign rs_nxt    = roff_r ? '0 : in_tdata[2*SB-1:SB];
  assign lthr_nxt  = {1'b0, llow_r} + {1'b0, ldz_r};
  assign rthr_nxt  = {1'b0, rlow_r} + {1'b0, rdz_r};

  // shared multiplier, left in S_MUL_L, right otherwise
  logic          sel_left;
  logic [SB:0]   dl_full, dr_full;
  logic [SB-1:0] diff_l, diff_r, mul_a;
  logic [QW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [2*SB-1:0] shifted;
  logic [SB-1:0] sat_v;

  assign sel_left = (state_r == S_MUL_L);
  assign dl_full  = {1'b0, ls_r} - lthr_r;
  assign dr_full  = {1'b0, rs_r} - rthr_r;
  assign diff_l   = ({1'b0, ls_r} >= lthr_r) ? dl_full[SB-1:0] : '0;
  assign diff_r   = ({1'b0, rs_r} >= rthr_r) ? dr_full[SB-1:0] : '0;
  assign mul_a    = sel_left ? diff_l : diff_r;
  assign mul_b    = sel_left ? lscale_r : rscale_r;
  assign prod     = PW'(mul_a) * PW'(mul_b);
  assign shifted  = prod_r[PW-1:FB];
  assign sat_v    = (shifted[2*SB-1:SB] != '0) ? FULL : shifted[SB-1:0];

  // shared divider for both scale factors
  logic          div_start;
  logic [SB:0]   lspan, rspan;
  logic [SB-1:0] divisor;
  logic [QW-1:0] quotient;
  div_stat_t     div_stat;

  assign lspan     = {1'b0, lhigh_r} - lthr_r;
  assign rspan     = {1'b0, rhigh_r} - rthr_r;
  assign div_start = (state_r == S_DIV_L) || (state_r == S_DIV_R);
  assign divisor   = (state_r == S_DIV_L) ? lspan[SB-1:0] : rspan[SB-1:0];

  dtcs_divider #(
    .DW (QW),
    .VW (SB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIVIDEND),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cal_r       <= 1'b0;
      llow_r      <= '0;
      rlow_r      <= '0;
      lhigh_r     <= FULL;
      rhigh_r     <= FULL;
      lthr_r      <= '0;
      rthr_r      <= '0;
      lscale_r    <= UNITY;
      rscale_r    <= UNITY;
      ls_r        <= '0;
      rs_r        <= '0;
      lsc_r       <= '0;
      rsc_r       <= '0;
      ack_r       <= 1'b0;
      prod_r      <= '0;
      out_valid_r <= 1'b0;
      out_ls_r    <= '0;
      out_rs_r    <= '0;
      out_lsc_r   <= '0;
      out_rsc_r   <= '0;
      out_cal_r   <= 1'b0;
      out_ack_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            lsc_r <= '0;
            rsc_r <= '0;
            unique case (in_tuser)
              MODE_SAMPLE: begin
                ls_r  <= ls_nxt;
                rs_r  <= rs_nxt;
                ack_r <= 1'b0;
                if (cal_r) begin
                  if (ls_nxt < llow_r)  llow_r  <= ls_nxt;
                  if (rs_nxt < rlow_r)  rlow_r  <= rs_nxt;
                  if (ls_nxt > lhigh_r) lhigh_r <= ls_nxt;
                  if (rs_nxt > rhigh_r) rhigh_r <= rs_nxt;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_MUL_L;
                end
              end
              MODE_CAL_START: begin
                ls_r    <= '0;
                rs_r    <= '0;
                llow_r  <= FULL;
                rlow_r  <= FULL;
                lhigh_r <= '0;
                rhigh_r <= '0;
                cal_r   <= 1'b1;
                ack_r   <= 1'b1;
                state_r <= S_DONE;
              end
              MODE_CAL_STOP: begin
                ls_r    <= '0;
                rs_r    <= '0;
                cal_r   <= 1'b0;
                ack_r   <= 1'b1;
                lthr_r  <= lthr_nxt;
                rthr_r  <= rthr_nxt;
                state_r <= S_DIV_L;
              end
              MODE_RECOMPUTE: begin
                ls_r    <= '0;
                rs_r    <= '0;
                ack_r   <= 1'b0;
                lthr_r  <= lthr_nxt;
                rthr_r  <= rthr_nxt;
                state_r <= S_DIV_L;
              end
            endcase
          end
        end
        S_MUL_L: begin
          prod_r  <= prod;
          state_r <= S_MUL_R;
        end
        S_MUL_R: begin
          lsc_r   <= sat_v;
          prod_r  <= prod;
          state_r <= S_SAT_R;
        end
        S_SAT_R: begin
          rsc_r   <= sat_v;
          state_r <= S_DONE;
        end
        S_DIV_L: begin
          state_r <= S_WAIT_L;
        end
        S_WAIT_L: begin
          if (div_stat.done) begin
            // empty range gives a zero gain
            lscale_r <= ({1'b0, lhigh_r} > lthr_r) ? quotient : '0;
            state_r  <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          state_r <= S_WAIT_R;
        end
        S_WAIT_R: begin
          if (div_stat.done) begin
            rscale_r <= ({1'b0, rhigh_r} > rthr_r) ? quotient : '0;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_ls_r    <= ls_r;
            out_rs_r    <= rs_r;
            out_lsc_r   <= lsc_r;
            out_rsc_r   <= rsc_r;
            out_cal_r   <= cal_r;
            out_ack_r   <= ack_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_rsc_r, out_lsc_r, out_rs_r, out_ls_r});
  assign out_tuser  = {out_ack_r, out_cal_r};

  `DTCS_ASSERT_IMPL(a_div_in_wait, div_stat.busy || div_stat.done, state_r == S_WAIT_L || state_r == S_WAIT_R, "divider active outside a wait state")
  `DTCS_ASSERT_IMPL(a_scaled_not_cal, out_valid_r && (out_lsc_r != '0 || out_rsc_r != '0), !out_cal_r, "scaled output while calibrating")
  `DTCS_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while busy")

endmodule
